// ----- hw/rtl/gpat_pkg.sv -----
package gpat_pkg;

  // item kinds on the request channel
  typedef enum logic [1:0] {
    MODE_READ   = 2'd0,
    MODE_WRITE  = 2'd1,
    MODE_TICK   = 2'd2,
    MODE_UPDATE = 2'd3
  } mode_t;

  // configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_STICK_ENABLE  = 2'd0,
    REG_SWAP_AXES     = 2'd1,
    REG_TIMED_MODE    = 2'd2,
    REG_TIMEOUT_TICKS = 2'd3
  } cfg_reg_t;

  localparam int unsigned PADDR_W = 4;

  localparam logic [10:0]       AXIS_BASE_US  = 11'd24;
  localparam logic [16:0]       AXIS_SPAN_US  = 17'd660;
  localparam logic signed [7:0] POS_RANGE     = 8'sd64;
  localparam logic [15:0]       TIMEOUT_RESET = 16'd10000;
  localparam logic [7:0]        IDLE_BYTE     = 8'hff;

  function automatic logic signed [7:0] clamp_pos(input logic signed [7:0] p);
    logic signed [7:0] r;
    if (p < -POS_RANGE) r = -POS_RANGE;
    else if (p > POS_RANGE) r = POS_RANGE;
    else r = p;
    return r;
  endfunction

  // counter preset: pos+64 per read, or 24 + 660*(pos+64)/64 microseconds
  function automatic logic [10:0] load_value(input logic signed [7:0] pos,
                                             input logic timed);
    logic [7:0]  k;
    logic [16:0] prod;
    logic [10:0] r;
    k    = 8'(pos + POS_RANGE);
    prod = 17'(k) * AXIS_SPAN_US;
    if (timed) r = AXIS_BASE_US + 11'(prod[16:6]);
    else r = 11'(k);
    return r;
  endfunction

endpackage

// ----- hw/rtl/gpat_if.sv -----
interface gpat_req_if;
  import gpat_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        mode;
  logic              stick_select;
  logic signed [7:0] x_pos;
  logic signed [7:0] y_pos;
  logic [1:0]        buttons;

  modport source (output valid, mode, stick_select, x_pos, y_pos, buttons,
                  input ready);
  modport sink (input valid, mode, stick_select, x_pos, y_pos, buttons,
                output ready);
endinterface

interface gpat_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;

  modport source (output valid, read_data, input ready);
  modport sink (input valid, read_data, output ready);
endinterface

// ----- hw/rtl/game_port_axis_timer.sv -----
// each accepted item's status byte is registered in the output register
// throughput: one item per cycle unless stalled; output refilled in the cycle it drains
// every item is finished by one pass of logic between the request and the output register
// reset (rst, synchronous, active high): counters, positions, buttons, timeout state and
// output valid clear; stick_enable, swap_axes, timed_mode go to 0, timeout_ticks to 10000
module game_port_axis_timer
  import gpat_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // item channels
  gpat_req_if.sink           req,
  gpat_rsp_if.source         rsp
);

  // configuration registers
  logic [1:0]  stick_enable;
  logic        swap_axes;
  logic        timed_mode;
  logic [15:0] timeout_ticks;

  // block state
  logic [10:0]       axis_counter [4];
  logic signed [7:0] stick_position [4];
  logic [3:0]        buttons_held;
  logic [15:0]       since_write;
  logic              write_pending;

  logic [10:0]       axis_counter_next [4];
  logic signed [7:0] stick_position_next [4];
  logic [3:0]        buttons_held_next;
  logic [15:0]       since_write_next;
  logic              write_pending_next;

  // output register
  logic        out_valid;
  logic [7:0]  read_data;
  logic [7:0]  read_data_next;

  logic        accept;
  logic        cfg_write;
  logic        timeout_clear;
  cfg_reg_t    cfg_sel;

  // ---------------------------------------------------------------
  // configuration port: always ready, write on the access phase
  // ---------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;
  assign cfg_sel   = cfg_reg_t'(paddr[3:2]);

  always_comb begin
    unique case (cfg_sel)
      REG_STICK_ENABLE:  prdata = {30'd0, stick_enable};
      REG_SWAP_AXES:     prdata = {31'd0, swap_axes};
      REG_TIMED_MODE:    prdata = {31'd0, timed_mode};
      REG_TIMEOUT_TICKS: prdata = {16'd0, timeout_ticks};
      default:           prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stick_enable  <= 2'd0;
      swap_axes     <= 1'b0;
      timed_mode    <= 1'b0;
      timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_STICK_ENABLE:  stick_enable  <= pwdata[1:0];
        REG_SWAP_AXES:     swap_axes     <= pwdata[0];
        REG_TIMED_MODE:    timed_mode    <= pwdata[0];
        REG_TIMEOUT_TICKS: timeout_ticks <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------
  // handshake: take a new item whenever the output slot is free or
  // is being emptied in this cycle
  // ---------------------------------------------------------------
  assign req.ready     = !out_valid || rsp.ready;
  assign accept        = req.valid && req.ready;
  assign rsp.valid     = out_valid;
  assign rsp.read_data = read_data;

  // a count-mode read long after the last write drops all one-shots first
  assign timeout_clear = !timed_mode && write_pending && (since_write > timeout_ticks);

  // ---------------------------------------------------------------
  // per-item update of the state and the status byte
  // ---------------------------------------------------------------
  always_comb begin
    axis_counter_next   = axis_counter;
    stick_position_next = stick_position;
    buttons_held_next   = buttons_held;
    since_write_next    = since_write;
    write_pending_next  = write_pending;
    read_data_next      = IDLE_BYTE;

    unique case (mode_t'(req.mode))
      MODE_READ: begin
        if (timeout_clear) begin
          write_pending_next = 1'b0;
          for (int i = 0; i < 4; i++) axis_counter_next[i] = 11'd0;
        end
        // axis i belongs to stick i/2; disabled sticks keep their bits high
        for (int i = 0; i < 4; i++) begin
          if (stick_enable[i/2]) begin
            if (!timeout_clear && axis_counter[i] != 11'd0) begin
              if (!timed_mode) axis_counter_next[i] = axis_counter[i] - 11'd1;
            end else begin
              read_data_next[i] = 1'b0;
            end
            if (buttons_held[i]) read_data_next[4+i] = 1'b0;
          end
        end
      end
      MODE_WRITE: begin
        // timed mode leaves the read timeout alone
        if (!timed_mode) begin
          write_pending_next = 1'b1;
          since_write_next   = 16'd0;
        end
        if (stick_enable[0]) begin
          axis_counter_next[0] = load_value(stick_position[0], timed_mode);
          axis_counter_next[1] = load_value(stick_position[1], timed_mode);
        end
        if (stick_enable[1]) begin
          axis_counter_next[2] = load_value(swap_axes ? stick_position[3]
                                                      : stick_position[2], timed_mode);
          axis_counter_next[3] = load_value(swap_axes ? stick_position[2]
                                                      : stick_position[3], timed_mode);
        end
      end
      MODE_TICK: begin
        // saturating microsecond count since the last write
        if (since_write != 16'hffff) since_write_next = since_write + 16'd1;
        if (timed_mode) begin
          for (int i = 0; i < 4; i++) begin
            if (axis_counter[i] != 11'd0) axis_counter_next[i] = axis_counter[i] - 11'd1;
          end
        end
      end
      MODE_UPDATE: begin
        if (req.stick_select) begin
          stick_position_next[2]  = clamp_pos(req.x_pos);
          stick_position_next[3]  = clamp_pos(req.y_pos);
          buttons_held_next[3:2]  = req.buttons;
        end else begin
          stick_position_next[0]  = clamp_pos(req.x_pos);
          stick_position_next[1]  = clamp_pos(req.y_pos);
          buttons_held_next[1:0]  = req.buttons;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        axis_counter[i]   <= 11'd0;
        stick_position[i] <= 8'sd0;
      end
      buttons_held  <= 4'd0;
      since_write   <= 16'd0;
      write_pending <= 1'b0;
    end else if (accept) begin
      axis_counter   <= axis_counter_next;
      stick_position <= stick_position_next;
      buttons_held   <= buttons_held_next;
      since_write    <= since_write_next;
      write_pending  <= write_pending_next;
    end
  end

  // output register: valid is control, the byte is payload
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      read_data <= read_data_next;
    end
  end

endmodule

// ----- hw/rtl/gpat_checker.sv -----
module gpat_checker
  import gpat_pkg::*;
(
  input logic       clk,
  input logic       rst,
  input logic       req_valid,
  input logic       req_ready,
  input logic [1:0] req_mode,
  input logic       rsp_valid,
  input logic       rsp_ready,
  input logic [7:0] rsp_read_data
);

  logic req_take;
  assign req_take = req_valid && req_ready;

  // every accepted item shows its byte in the next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    req_take |=> rsp_valid)
    else $error("accepted item produced no result");

  // items other than reads answer with an all-ones byte
  a_idle_byte: assert property (@(posedge clk) disable iff (rst)
    req_take && (req_mode != MODE_READ) |=> rsp_read_data == IDLE_BYTE)
    else $error("non-read item gave a status byte");

  // a held result blocks new items
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |-> !req_ready)
    else $error("item accepted while result stalled");

  // stalled result keeps its byte
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
    else $error("stalled result changed");

endmodule

bind game_port_axis_timer gpat_checker u_gpat_checker (
  .clk           (clk),
  .rst           (rst),
  .req_valid     (req.valid),
  .req_ready     (req.ready),
  .req_mode      (req.mode),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .rsp_read_data (rsp.read_data)
);

// ----- dv/game_port_axis_timer_test.sv -----
// game port status register: checks every status byte against a cycle-free model
// of the four axis one-shots, the stick positions and buttons, and the count-mode
// timeout, while the request side sends in bursts and the response side stalls
module game_port_axis_timer_test;
  import gpat_pkg::*;

  // one request item as the driver holds it
  typedef struct packed {
    mode_t             mode;
    logic              sel;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic [1:0]        btn;
  } port_item_t;

  // longest quiet stretch: sender gaps, receiver stalls, register writes, drains
  localparam int QUIET_LIMIT = 2000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  gpat_req_if req ();
  gpat_rsp_if rsp ();

  game_port_axis_timer dut (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .req     (req),
    .rsp     (rsp)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // port model: register copies and the state of sticks and one-shots
  // ---------------------------------------------------------------------------
  logic [1:0]        cfg_enable;
  logic              cfg_swap;
  logic              cfg_timed;
  logic [15:0]       cfg_timeout;
  logic [10:0]       axis_cnt [4];   // stick0 x, stick0 y, stick1 x, stick1 y
  logic signed [7:0] stick_pos [4];  // same order, always within -64..64
  logic [3:0]        btn_held;       // bit 2*stick+button
  logic [15:0]       ticks_since_write;
  logic              write_armed;    // count-mode write not yet timed out

  port_item_t item_q[$];     // items waiting for the driver
  logic [7:0] status_q[$];   // status bytes owed by the block, oldest first

  int n_mode [4];
  int n_checked;
  int n_errors;
  int n_settings;

  function automatic logic signed [7:0] saturate_pos(input logic signed [7:0] p);
    if (p < -8'sd64) return -8'sd64;
    if (p > 8'sd64) return 8'sd64;
    return p;
  endfunction

  // one-shot preset for a stored position
  function automatic logic [10:0] preset(input logic signed [7:0] p);
    int k;
    k = int'(p) + 64;
    if (cfg_timed) return 11'(24 + (660 * k) / 64);
    return 11'(k);
  endfunction

  // applies one item to the model and returns the byte the block must answer with
  function automatic logic [7:0] port_status(input port_item_t it);
    logic [7:0] b;
    int i;
    int s;
    b = 8'hff;
    s = int'(it.sel);
    case (it.mode)
      MODE_READ: begin
        // stale count-mode write: all one-shots drop before the byte is formed
        if (!cfg_timed && write_armed && ticks_since_write > cfg_timeout) begin
          write_armed = 1'b0;
          for (i = 0; i < 4; i++) axis_cnt[i] = '0;
        end
        for (i = 0; i < 4; i++) begin
          if (cfg_enable[i / 2]) begin
            if (axis_cnt[i] != 0) begin
              if (!cfg_timed) axis_cnt[i] = axis_cnt[i] - 11'd1;
            end else begin
              b[i] = 1'b0;
            end
            if (btn_held[i]) b[4 + i] = 1'b0;
          end
        end
      end
      MODE_WRITE: begin
        if (!cfg_timed) begin
          write_armed = 1'b1;
          ticks_since_write = '0;
        end
        if (cfg_enable[0]) begin
          axis_cnt[0] = preset(stick_pos[0]);
          axis_cnt[1] = preset(stick_pos[1]);
        end
        if (cfg_enable[1]) begin
          axis_cnt[2] = preset(cfg_swap ? stick_pos[3] : stick_pos[2]);
          axis_cnt[3] = preset(cfg_swap ? stick_pos[2] : stick_pos[3]);
        end
      end
      MODE_TICK: begin
        if (ticks_since_write != 16'hffff) ticks_since_write = ticks_since_write + 16'd1;
        if (cfg_timed)
          for (i = 0; i < 4; i++)
            if (axis_cnt[i] != 0) axis_cnt[i] = axis_cnt[i] - 11'd1;
      end
      default: begin
        stick_pos[2 * s]     = saturate_pos(it.x);
        stick_pos[2 * s + 1] = saturate_pos(it.y);
        btn_held[2 * s +: 2] = it.btn;
      end
    endcase
    return b;
  endfunction

  // ---------------------------------------------------------------------------
  // item builders
  // ---------------------------------------------------------------------------
  function automatic port_item_t op(input mode_t m, input logic s = 1'b0,
                                    input logic signed [7:0] x = '0,
                                    input logic signed [7:0] y = '0,
                                    input logic [1:0] b = '0);
    port_item_t it;
    it.mode = m;
    it.sel  = s;
    it.x    = x;
    it.y    = y;
    it.btn  = b;
    return it;
  endfunction

  // positions lean toward the low end so one-shots run out within a poll
  function automatic logic signed [7:0] rand_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'($urandom_range(0, 6) - 64);
    if (r < 6) return 8'($urandom);
    return 8'($urandom_range(0, 128) - 64);
  endfunction

  function automatic port_item_t rand_update(input logic s);
    return op(MODE_UPDATE, s, rand_pos(), rand_pos(), 2'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // driver: bursts of random length with random gaps
  // ---------------------------------------------------------------------------
  int burst_left;
  int gap_left;

  always @(posedge clk) begin
    port_item_t nxt;
    if (rst) begin
      req.valid  <= 1'b0;
      burst_left = 0;
      gap_left   = 0;
    end else begin
      // predict from the fields the block just took
      if (req.valid && req.ready) begin
        status_q.push_back(port_status(op(mode_t'(req.mode), req.stick_select,
                                          req.x_pos, req.y_pos, req.buttons)));
        n_mode[req.mode]++;
      end
      if (req.valid && !req.ready) begin
        // item still on offer, leave it alone
      end else if (gap_left > 0) begin
        gap_left--;
        req.valid <= 1'b0;
      end else if (item_q.size() > 0) begin
        nxt = item_q.pop_front();
        req.valid        <= 1'b1;
        req.mode         <= nxt.mode;
        req.stick_select <= nxt.sel;
        req.x_pos        <= nxt.x;
        req.y_pos        <= nxt.y;
        req.buttons      <= nxt.btn;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 24);
          // many bursts run back to back, a few end in a long gap
          if ($urandom_range(0, 9) < 4) gap_left = 0;
          else if ($urandom_range(0, 19) == 0) gap_left = $urandom_range(10, 30);
          else gap_left = $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        req.valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: compares status bytes, receiver stalls in changing styles
  // ---------------------------------------------------------------------------
  int rx_cycle;
  int rx_style;
  int rx_hold;

  always @(posedge clk) begin
    logic [7:0] want;
    if (rst) begin
      rsp.ready <= 1'b0;
      rx_cycle = 0;
      rx_style = 0;
      rx_hold  = 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (status_q.size() == 0) begin
          n_errors++;
          $display("%0t: read_data with nothing owed, expected none actual %02h",
                   $time, rsp.read_data);
        end else begin
          want = status_q.pop_front();
          n_checked++;
          if (rsp.read_data !== want) begin
            n_errors++;
            $display("%0t: read_data mismatch, expected %02h actual %02h",
                     $time, want, rsp.read_data);
          end
        end
      end
      rx_cycle++;
      if (rx_cycle % 97 == 0) rx_style = $urandom_range(0, 3);
      case (rx_style)
        0: rsp.ready <= 1'b1;
        1: rsp.ready <= (rx_cycle % 4 != 3);
        2: rsp.ready <= 1'($urandom);
        default: begin
          // mostly ready with an occasional long stall
          if (rx_hold > 0) begin
            rx_hold--;
            rsp.ready <= 1'b0;
          end else begin
            if ($urandom_range(0, 15) == 0) rx_hold = $urandom_range(4, 20);
            rsp.ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // watchdog: too long without any item moving on either channel
  int quiet;

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (rsp.valid && rsp.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QUIET_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, quiet);
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // register access and phase control
  // ---------------------------------------------------------------------------
  task automatic reg_write(input cfg_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    // register takes the value at the access edge with pready high
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_STICK_ENABLE: cfg_enable  = val[1:0];
      REG_SWAP_AXES:    cfg_swap    = val[0];
      REG_TIMED_MODE:   cfg_timed   = val[0];
      default:          cfg_timeout = val[15:0];
    endcase
  endtask

  // every owed byte back and the sender empty
  task automatic wait_idle();
    while (item_q.size() != 0 || req.valid || status_q.size() != 0) @(negedge clk);
    repeat (3) @(negedge clk);
  endtask

  task automatic set_port(input logic [1:0] en, input logic swap, input logic timed,
                          input logic [15:0] tmo);
    wait_idle();
    reg_write(REG_STICK_ENABLE, 32'(en));
    reg_write(REG_SWAP_AXES, 32'(swap));
    reg_write(REG_TIMED_MODE, 32'(timed));
    reg_write(REG_TIMEOUT_TICKS, 32'(tmo));
    n_settings++;
  endtask

  // mostly set-up / fire / poll sequences, the rest raw noise on every field
  task automatic queue_random_items(input int n);
    int left;
    int k;
    int r;
    left = n;
    while (left > 0) begin
      if ($urandom_range(0, 9) < 7) begin
        item_q.push_back(rand_update(1'b0));
        item_q.push_back(rand_update(1'b1));
        item_q.push_back(op(MODE_WRITE));
        k = $urandom_range(4, cfg_timed ? 90 : 45);
        repeat (k) begin
          r = $urandom_range(0, 9);
          // ticks drive timed mode, reads drive count mode
          if (r == 0) item_q.push_back(rand_update(1'($urandom)));
          else if (cfg_timed ? r < 3 : r < 7) item_q.push_back(op(MODE_READ));
          else item_q.push_back(op(MODE_TICK));
        end
        left -= k + 3;
      end else begin
        repeat (8)
          item_q.push_back(op(mode_t'($urandom_range(0, 3)), 1'($urandom),
                              8'($urandom), 8'($urandom), 2'($urandom)));
        left -= 8;
      end
    end
  endtask

  // a random phase, with the sender held halfway until all bytes are back
  task automatic random_phase(input logic [1:0] en, input logic swap, input logic timed,
                              input logic [15:0] tmo);
    set_port(en, swap, timed, tmo);
    queue_random_items(45);
    wait_idle();
    queue_random_items(45);
  endtask

  initial begin
    int i;
    req.valid        = 1'b0;
    req.mode         = MODE_READ;
    req.stick_select = 1'b0;
    req.x_pos        = '0;
    req.y_pos        = '0;
    req.buttons      = '0;
    rsp.ready        = 1'b0;

    cfg_enable        = '0;
    cfg_swap          = 1'b0;
    cfg_timed         = 1'b0;
    cfg_timeout       = 16'd10000;
    btn_held          = '0;
    ticks_since_write = '0;
    write_armed       = 1'b0;
    for (i = 0; i < 4; i++) begin
      axis_cnt[i]  = '0;
      stick_pos[i] = '0;
      n_mode[i]    = 0;
    end
    n_checked  = 0;
    n_errors   = 0;
    n_settings = 0;

    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // both sticks off after reset: every byte reads all ones
    item_q.push_back(op(MODE_READ));
    item_q.push_back(op(MODE_UPDATE, 1'b0, 8'h80, 8'sd127, 2'd3));  // saturate both ways
    item_q.push_back(op(MODE_WRITE));
    item_q.push_back(op(MODE_READ));

    // count mode, both sticks on; stick0 x runs out after one read
    set_port(2'd3, 1'b0, 1'b0, 16'd10000);
    item_q.push_back(op(MODE_UPDATE, 1'b1, 8'sd64, -8'sd64, 2'd2));
    item_q.push_back(op(MODE_UPDATE, 1'b0, -8'sd63, -8'sd65, 2'd1));
    item_q.push_back(op(MODE_WRITE));
    item_q.push_back(op(MODE_READ));
    item_q.push_back(op(MODE_READ));
    item_q.push_back(op(MODE_TICK));   // no effect on counters in count mode
    item_q.push_back(op(MODE_READ));

    // zero timeout with swapped stick1: any tick after the write clears on read
    set_port(2'd3, 1'b1, 1'b0, 16'd0);
    item_q.push_back(op(MODE_UPDATE, 1'b1, -8'sd20, 8'sd5, 2'd0));
    item_q.push_back(op(MODE_WRITE));
    item_q.push_back(op(MODE_READ));
    item_q.push_back(op(MODE_TICK));
    item_q.push_back(op(MODE_READ));

    // timed mode: longest and shortest presets, write leaves timeout state alone
    set_port(2'd2, 1'b1, 1'b1, 16'd65535);
    item_q.push_back(op(MODE_UPDATE, 1'b1, 8'sd64, -8'sd64, 2'd3));
    item_q.push_back(op(MODE_WRITE));
    item_q.push_back(op(MODE_READ));
    item_q.push_back(op(MODE_TICK));
    item_q.push_back(op(MODE_READ));

    // random part over a spread of settings, extremes included
    random_phase(2'd3, 1'b0, 1'b0, 16'd10000);
    random_phase(2'd3, 1'b1, 1'b0, 16'd5);
    random_phase(2'd1, 1'b0, 1'b1, 16'd0);
    random_phase(2'd2, 1'b1, 1'b1, 16'd65535);
    random_phase(2'd3, 1'b0, 1'b0, 16'd0);
    random_phase(2'd0, 1'b1, 1'b0, 16'd3);
    random_phase(2'd3, 1'b1, 1'b1, 16'd1);
    random_phase(2'($urandom), 1'($urandom), 1'($urandom), 16'($urandom_range(1, 40)));

    wait_idle();
    repeat (10) @(negedge clk);

    $display("covered %0d reads, %0d writes, %0d ticks, %0d updates over %0d settings",
             n_mode[MODE_READ], n_mode[MODE_WRITE], n_mode[MODE_TICK],
             n_mode[MODE_UPDATE], n_settings);
    $display("%0d status bytes checked, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0 && status_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
